@@ hdl/kda_pkg.sv @@
// ----------------------------------------------------------------------------
// kda_pkg
// Types, register indexes and helpers for the debounced key with autorepeat.
// ----------------------------------------------------------------------------
package kda_pkg;

    // Timer and register widths
    localparam int TIMER_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_ADDR_W = 3;

    // Result queue depth (holds two ticks' worth of events)
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [TIMER_W-1:0] timer_t;
    typedef logic [CFG_W-1:0]   cfg_word_t;

    localparam timer_t TIMER_MAX = '1;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_CODE      = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_AUTOREPEAT_ON = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE      = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_DELAY  = CFG_ADDR_W'(3);
    localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_PERIOD = CFG_ADDR_W'(4);

    // Register reset values
    localparam cfg_word_t DEBOUNCE_RST      = CFG_W'(5);
    localparam cfg_word_t REPEAT_DELAY_RST  = CFG_W'(250);
    localparam cfg_word_t REPEAT_PERIOD_RST = CFG_W'(34);

    // One tick beat
    typedef struct packed {
        logic pin_level;
        logic pin_change;
    } kda_in_t;

    // One event beat
    typedef struct packed {
        logic [15:0] event_code;
        logic        pressed;
        logic        last;
    } kda_out_t;

    // Timer load value: zero counts as one, large values saturate
    function automatic timer_t load_value(input cfg_word_t ticks);
        logic [32:0] t_wide;
        t_wide = 33'(ticks);
        if (ticks == '0) begin
            return TIMER_W'(1);
        end else if (t_wide > 33'(TIMER_MAX)) begin
            return TIMER_MAX;
        end else begin
            return TIMER_W'(ticks);
        end
    endfunction

endpackage

@@ hdl/key_debounce_autorepeat_top.sv @@
// ----------------------------------------------------------------------------
// key_debounce_autorepeat_top
// Debounced key with optional autorepeat, one tick beat per cycle while the queue has room.
// ----------------------------------------------------------------------------
//  channel  | ports                     | payload
//  ---------+---------------------------+-----------------------------------
//  tick in  | s_valid, s_ready, s_data  | pin_level, pin_change
//  event out| m_valid, m_ready, m_data  | event_code, pressed, last
//  config   | cfg_wr_en, cfg_addr, cfg_wdata | five registers, write only
//
//  A tick is processed in the cycle it is accepted: both timers update at
//  that edge and its zero to two events enter a four-entry result queue.
//  A tick is taken whenever the queue has room for two events, so ticks
//  flow one per cycle while the event side keeps up; each event leaves as
//  its own output beat, which sets the rate when ticks keep producing events.
//  Synchronous reset clears timers and queue and restores register defaults.
// ----------------------------------------------------------------------------
module key_debounce_autorepeat_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [kda_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [kda_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  kda_pkg::kda_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output kda_pkg::kda_out_t             m_data
);
    import kda_pkg::*;

    // Configuration registers
    logic [15:0] key_code_reg;
    logic        autorepeat_on_reg;
    cfg_word_t   debounce_reg;
    cfg_word_t   repeat_delay_reg;
    cfg_word_t   repeat_period_reg;

    // Timers
    timer_t deb_reg, deb_next;
    timer_t rep_reg, rep_next;

    // Result queue
    kda_out_t            queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    logic        accept;
    logic        pop;
    logic        key_on;
    logic        rep_fire;
    logic        deb_fire;
    timer_t      deb_after;
    logic [1:0]  push_n;
    kda_out_t    ev_rep;
    kda_out_t    ev_deb;
    logic [QPTR_W-1:0] wr_ptr_second;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_code_reg      <= '0;
            autorepeat_on_reg <= 1'b0;
            debounce_reg      <= DEBOUNCE_RST;
            repeat_delay_reg  <= REPEAT_DELAY_RST;
            repeat_period_reg <= REPEAT_PERIOD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_KEY_CODE:      key_code_reg      <= cfg_wdata[15:0];
                REG_AUTOREPEAT_ON: autorepeat_on_reg <= cfg_wdata[0];
                REG_DEBOUNCE:      debounce_reg      <= cfg_wdata;
                REG_REPEAT_DELAY:  repeat_delay_reg  <= cfg_wdata;
                REG_REPEAT_PERIOD: repeat_period_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake
    assign s_ready = (cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign accept  = s_valid && s_ready;
    assign m_valid = (cnt_reg != '0);
    assign pop     = m_valid && m_ready;
    assign m_data  = queue_reg[rd_ptr_reg];

    // Advance timers and decide events for the accepted tick
    always_comb begin
        key_on    = (key_code_reg != '0);
        rep_fire  = (rep_reg == TIMER_W'(1)) && key_on;
        deb_fire  = (deb_reg == TIMER_W'(1)) && key_on;
        deb_after = (deb_reg == '0) ? '0 : deb_reg - TIMER_W'(1);

        // repeat timer first
        if (rep_reg == '0) begin
            rep_next = '0;
        end else if (rep_fire) begin
            rep_next = load_value(repeat_period_reg);
        end else begin
            rep_next = rep_reg - TIMER_W'(1);
        end

        // debounce expiry samples the pin
        if (deb_fire) begin
            if (!s_data.pin_level) begin
                if (autorepeat_on_reg) begin
                    rep_next = load_value(repeat_delay_reg);
                end
            end else begin
                rep_next = '0;
            end
        end

        // pin change arms an idle debounce timer
        deb_next = deb_after;
        if (s_data.pin_change && (deb_after == '0)) begin
            deb_next = load_value(debounce_reg);
        end

        ev_rep.event_code = key_code_reg;
        ev_rep.pressed    = 1'b1;
        ev_rep.last       = !deb_fire;
        ev_deb.event_code = key_code_reg;
        ev_deb.pressed    = !s_data.pin_level;
        ev_deb.last       = 1'b1;

        push_n        = accept ? ({1'b0, rep_fire} + {1'b0, deb_fire}) : 2'd0;
        wr_ptr_second = wr_ptr_reg + QPTR_W'(rep_fire);
        wr_ptr_next   = wr_ptr_reg + QPTR_W'(push_n);
        rd_ptr_next   = rd_ptr_reg + QPTR_W'(pop);
        cnt_next      = cnt_reg + QCNT_W'(push_n) - QCNT_W'(pop);
    end

    // Hold timer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_reg <= '0;
            rep_reg <= '0;
        end else if (accept) begin
            deb_reg <= deb_next;
            rep_reg <= rep_next;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Push events into the queue
    always_ff @(posedge aclk) begin
        if (accept && rep_fire) begin
            queue_reg[wr_ptr_reg] <= ev_rep;
        end
        if (accept && deb_fire) begin
            queue_reg[wr_ptr_second] <= ev_deb;
        end
    end

`ifndef SYNTHESIS
    // Queue never overfills
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // An armed debounce timer is never left at zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.pin_change && (deb_after == '0) |=> deb_reg != '0)
        else $error("debounce timer armed with zero");

    // Timers move only on an accepted tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(deb_reg) && $stable(rep_reg))
        else $error("timer changed without a tick");

    // A tick with two events leaves at least two queued
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && rep_fire && deb_fire |=> cnt_reg >= QCNT_W'(2))
        else $error("second event lost");
`endif

endmodule

@@ bench/key_event_checker.sv @@
// ----------------------------------------------------------------------------
// key_event_checker
// Watches the tick, event and register ports of the debounced key, keeps its
// own copy of the registers and of both timers, predicts the events of every
// accepted tick and compares each accepted event against the oldest one due.
// ----------------------------------------------------------------------------
module key_event_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [kda_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [kda_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  kda_pkg::kda_in_t               s_data,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  kda_pkg::kda_out_t              m_data,
    output int                             events_pending,
    output int                             mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import kda_pkg::*;

    // Register copy
    logic [15:0] key_code_q    = '0;
    logic        repeat_on_q   = 1'b0;
    cfg_word_t   debounce_q    = DEBOUNCE_RST;
    cfg_word_t   delay_q       = REPEAT_DELAY_RST;
    cfg_word_t   period_q      = REPEAT_PERIOD_RST;

    // Timer copy, zero means idle
    timer_t      debounce_left = '0;
    timer_t      repeat_left   = '0;

    // Events predicted but not yet seen on the output
    kda_out_t    events_due[$];

    // A tick count of zero still runs the timer for one tick
    function automatic timer_t load_count(input cfg_word_t ticks);
        if (ticks == '0) begin
            return timer_t'(1);
        end
        return timer_t'(ticks);
    endfunction

    // Advance both timers by one tick and queue the events it causes
    task automatic advance_tick(input kda_in_t tick);
        kda_out_t made[$];
        kda_out_t ev;
        ev.event_code = key_code_q;
        ev.pressed    = 1'b1;
        ev.last       = 1'b0;
        // repeat timer first: an expiry repeats the press and reloads
        if (repeat_left != '0) begin
            repeat_left = repeat_left - 1'b1;
            if (repeat_left == '0 && key_code_q != '0) begin
                made.push_back(ev);
                repeat_left = load_count(period_q);
            end
        end
        // debounce expiry samples the pin
        if (debounce_left != '0) begin
            debounce_left = debounce_left - 1'b1;
            if (debounce_left == '0 && key_code_q != '0) begin
                if (tick.pin_level == 1'b0) begin
                    made.push_back(ev);
                    if (repeat_on_q) begin
                        repeat_left = load_count(delay_q);
                    end
                end else begin
                    repeat_left = '0;
                    ev.pressed  = 1'b0;
                    made.push_back(ev);
                end
            end
        end
        // a pin change arms the debounce timer only when it is idle
        if (tick.pin_change && debounce_left == '0) begin
            debounce_left = load_count(debounce_q);
        end
        if (made.size() > 0) begin
            made[made.size() - 1].last = 1'b1;
        end
        foreach (made[i]) begin
            events_due.push_back(made[i]);
        end
    endtask

    // Track writes and ticks, then check the event beat of this edge
    always @(posedge aclk) begin : watch
        kda_out_t want;
        if (!aresetn) begin
            key_code_q     = '0;
            repeat_on_q    = 1'b0;
            debounce_q     = DEBOUNCE_RST;
            delay_q        = REPEAT_DELAY_RST;
            period_q       = REPEAT_PERIOD_RST;
            debounce_left  = '0;
            repeat_left    = '0;
            events_due.delete();
            mismatch_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_KEY_CODE:      key_code_q  = cfg_wdata;
                    REG_AUTOREPEAT_ON: repeat_on_q = cfg_wdata[0];
                    REG_DEBOUNCE:      debounce_q  = cfg_wdata;
                    REG_REPEAT_DELAY:  delay_q     = cfg_wdata;
                    REG_REPEAT_PERIOD: period_q    = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                advance_tick(s_data);
            end
            if (m_valid && m_ready) begin
                if (events_due.size() == 0) begin
                    $error("event beat with none due: event_code %h pressed %b last %b",
                           m_data.event_code, m_data.pressed, m_data.last);
                    mismatch_count++;
                end else begin
                    want = events_due.pop_front();
                    if (m_data.event_code !== want.event_code) begin
                        $error("event_code: expected %h, got %h",
                               want.event_code, m_data.event_code);
                        mismatch_count++;
                    end
                    if (m_data.pressed !== want.pressed) begin
                        $error("pressed: expected %b, got %b", want.pressed, m_data.pressed);
                        mismatch_count++;
                    end
                    if (m_data.last !== want.last) begin
                        $error("last: expected %b, got %b", want.last, m_data.last);
                        mismatch_count++;
                    end
                end
            end
        end
        events_pending = events_due.size();
    end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives tick beats and register writes into the debounced key, stalls the
// event side on a pattern of its own and gives the verdict from the checker.
// Directed ticks come first, then random keystrokes with bounce and noise
// under many register settings, a back-pressure run, and short runs with
// full-range timer settings.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kda_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_TICKS  = 1450;
    localparam int PRESSURE_AT   = 900;
    localparam int LONG_HOLD     = 400;
    localparam int LONG_TICKS    = 100;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 200_000;
    localparam logic [15:0] FULL_RANGE = 16'hFFFF;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_FIRST = REG_REPEAT_PERIOD + 1'b1;

    typedef enum {RX_STEADY, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    kda_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    kda_out_t              m_data;

    int       events_pending;
    int       mismatch_count;
    int       items_sent  = 0;
    int       burst_left  = 0;
    int       cycle_count = 0;
    bit       hold_req    = 1'b0;
    rx_mode_t rx_mode     = RX_STEADY;
    int       rx_left     = 0;

    key_debounce_autorepeat_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    key_event_checker events_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .events_pending (events_pending),
        .mismatch_count (mismatch_count)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Bound the run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Event side: switch stall patterns now and then, hold off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(32, 400);
            end
            rx_left--;
            case (rx_mode)
                RX_STEADY: m_ready <= 1'b1;
                RX_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                RX_TOGGLE: m_ready <= ~m_ready;
                default:   m_ready <= 1'b1;
            endcase
        end
    end

    // Offer one tick beat and hold it until accepted; bursts with random gaps
    task automatic push_tick(input logic level, input logic change);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= '{pin_level: level, pin_change: change};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
    endtask

    // Stop offering and wait until every predicted event has come out
    task automatic settle();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(negedge aclk); while (events_pending != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge aclk);
    endtask

    // Write all five registers, plus one write to an unused index
    task automatic apply_config(input logic [15:0] key, input logic [15:0] repeat_on,
                                input logic [15:0] debounce, input logic [15:0] delay,
                                input logic [15:0] period);
        put_reg(REG_KEY_CODE, key);
        put_reg(REG_AUTOREPEAT_ON, repeat_on);
        put_reg(REG_DEBOUNCE, debounce);
        put_reg(REG_REPEAT_DELAY, delay);
        put_reg(REG_REPEAT_PERIOD, period);
        put_reg(REG_SPARE_FIRST + CFG_ADDR_W'($urandom_range(0, 2)), 16'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    // One keystroke: bounce, hold low, bounce, stay high; sometimes a glitch
    task automatic key_stroke();
        int n;
        n = $urandom_range(0, 3);
        repeat (n) push_tick(1'($urandom), 1'b1);
        push_tick(1'b0, 1'b1);
        n = $urandom_range(1, 40);
        repeat (n) begin
            if ($urandom_range(0, 15) == 0) begin
                push_tick(1'b1, 1'b1);
            end else begin
                push_tick(1'b0, 1'b0);
            end
        end
        n = $urandom_range(0, 3);
        repeat (n) push_tick(1'($urandom), 1'b1);
        push_tick(1'b1, 1'b1);
        n = $urandom_range(1, 20);
        repeat (n) push_tick(1'b1, 1'b0);
    endtask

    // One random register setting, then keystrokes mixed with noise
    task automatic random_phase();
        logic [15:0] key;
        int          stop_at;
        case ($urandom_range(0, 7))
            0:       key = '0;
            1:       key = FULL_RANGE;
            2:       key = 16'h0001;
            default: key = 16'($urandom_range(1, 65535));
        endcase
        apply_config(key, 16'($urandom), 16'($urandom_range(0, 6)),
                     16'($urandom_range(0, 24)), 16'($urandom_range(0, 10)));
        stop_at = items_sent + $urandom_range(40, 160);
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 4) == 0) begin
                push_tick(1'($urandom), 1'($urandom));
            end else begin
                key_stroke();
            end
        end
        settle();
    endtask

    // Stimulus
    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // key code zero after reset: timers run but report nothing
        push_tick(1'b0, 1'b1);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b1);
        settle();

        // zero tick counts act as one; repeat and debounce expire together
        apply_config(FULL_RANGE, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        repeat (3) push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b1);
        push_tick(1'b1, 1'b1);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        settle();

        // smallest key code, autorepeat off: release stops the repeat timer anyway
        apply_config(16'h0001, 16'h0000, 16'h0002, 16'h0003, 16'h0001);
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b1);
        push_tick(1'b1, 1'b0);
        push_tick(1'b1, 1'b0);
        settle();

        while (items_sent < PRESSURE_AT) begin
            random_phase();
        end

        // two events per tick while the event side holds off
        apply_config(16'h5A5A, 16'h0001, 16'h0001, 16'h0001, 16'h0001);
        push_tick(1'b0, 1'b1);
        hold_req = 1'b1;
        repeat (80) push_tick(1'b0, 1'b1);
        settle();

        while (items_sent < RANDOM_TICKS) begin
            random_phase();
        end

        // full-range repeat delay and period
        apply_config(16'hA5C3, 16'h0001, 16'h0001, FULL_RANGE, FULL_RANGE);
        push_tick(1'b0, 1'b1);
        repeat (LONG_TICKS) push_tick(1'b0, 1'b0);
        settle();

        // full-range debounce while the repeat timer keeps running
        apply_config(16'hA5C3, 16'h0001, FULL_RANGE, FULL_RANGE, FULL_RANGE);
        push_tick(1'b0, 1'b1);
        repeat (LONG_TICKS) push_tick(1'b0, 1'b0);
        settle();

        // release and stop
        apply_config(16'hA5C3, 16'h0001, 16'h0001, 16'h0004, 16'h0002);
        push_tick(1'b1, 1'b1);
        push_tick(1'b1, 1'b0);
        settle();

        repeat (20) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
